// ===== rtl/wspl_pkg.sv =====
// package for the wildcard stroke prefix lookup
// types, codes and defaults shared by the candidate cells and the top level
`timescale 1ns / 1ps

package wspl_pkg;

  localparam int unsigned MAX_STROKES_DEF    = 16;
  localparam int unsigned TABLE_DEPTH_DEF    = 1024;
  localparam int unsigned MAX_CANDIDATES_DEF = 64;

  localparam int unsigned SEQ_W   = 48;
  localparam int unsigned CHAR_W  = 21;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned LEN_W   = 5;

  localparam logic [2:0] WILDCARD = 3'd7;

  typedef enum logic [1:0] {
    REQ_CLEAR = 2'd0,
    REQ_LOAD  = 2'd1,
    REQ_QUERY = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LONG  = 3'd1,
    ST_BAD_STROKE = 3'd2,
    ST_FULL      = 3'd3,
    ST_BAD_REC   = 3'd4,
    ST_MISORDER  = 3'd5,
    ST_TRUNC     = 3'd6
  } status_t;

  // one candidate as it travels along the cell row
  typedef struct packed {
    logic               vld;
    logic [CHAR_W-1:0]  ch;
    logic [SCORE_W-1:0] score;
    logic               exact;
  } cand_t;

endpackage

// ===== rtl/wspl_cell.sv =====
// one cell of the sorted candidate row
// keeps one candidate and passes the displaced one to its right neighbor; uses wspl_pkg
`timescale 1ns / 1ps

module wspl_cell (
  input  logic           clk,
  input  logic           clr,
  input  logic           ins_en,
  input  wspl_pkg::cand_t in_cand,
  input  logic           shift_en,
  input  wspl_pkg::cand_t shift_in,
  output wspl_pkg::cand_t held,
  output wspl_pkg::cand_t pass_out
);

  wspl_pkg::cand_t slot;
  wspl_pkg::cand_t carry;

  assign held = slot;
  assign pass_out = carry;

  always_ff @(posedge clk) begin
    if (clr) begin
      slot.vld  <= 1'b0;
      carry.vld <= 1'b0;
    end else if (shift_en) begin
      // drain: each cell takes the slot of its right neighbor
      slot  <= shift_in;
      carry.vld <= 1'b0;
    end else if (ins_en && in_cand.vld) begin
      if (!slot.vld || in_cand.ch < slot.ch) begin
        slot  <= in_cand;
        carry <= slot;
      end else if (in_cand.ch == slot.ch) begin
        if (in_cand.score > slot.score) slot.score <= in_cand.score;
        slot.exact <= slot.exact | in_cand.exact;
        carry.vld  <= 1'b0;
      end else begin
        carry <= in_cand;
      end
    end else if (ins_en) begin
      carry.vld <= 1'b0;
    end
  end

endmodule

// ===== rtl/wildcard_stroke_prefix_lookup.sv =====
// wildcard stroke prefix lookup, top level: record memory, loader checks, query scan
// a query scans the table, flushes the row, then gives one result per cycle while m_tready is high;
// loads go through S_LOAD and S_ONE, clears and rejects through S_ONE, then S_IDLE before the next request is taken
// sorted merge runs through a row of MAX_CANDIDATES wspl_cell instances
// synchronous reset empties the table (rec_count 0); memories are not cleared
// uses wspl_pkg and wspl_cell
`timescale 1ns / 1ps

module wildcard_stroke_prefix_lookup #(
  parameter int unsigned MAX_STROKES    = wspl_pkg::MAX_STROKES_DEF,
  parameter int unsigned TABLE_DEPTH    = wspl_pkg::TABLE_DEPTH_DEF,
  parameter int unsigned MAX_CANDIDATES = wspl_pkg::MAX_CANDIDATES_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  // tdata: stroke_count[4:0], stroke_codes[52:5], code_point[73:53], weight[105:74], pad
  input  logic [111:0]  s_tdata,
  // tuser: req_type[1:0]
  input  logic [1:0]    s_tuser,
  output logic          m_tvalid,
  input  logic          m_tready,
  // tdata: status[2:0], has_candidate[3], cand_char[24:4], cand_score[56:25],
  //        exact_hit[57], pad
  output logic [63:0]   m_tdata,
  output logic          m_tlast
);

  localparam int unsigned AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NC = MAX_CANDIDATES;
  localparam int unsigned KW = $clog2(NC + 1);
  localparam int unsigned SW = 3 * MAX_STROKES;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_FLUSH = 6'b000100,
    S_OUT   = 6'b001000,
    S_ONE   = 6'b010000,
    S_LOAD  = 6'b100000
  } state_t;

  state_t state;

  logic [1:0]                 f_req;
  logic [wspl_pkg::LEN_W-1:0] f_len;
  logic [wspl_pkg::SEQ_W-1:0] f_seq;
  logic [wspl_pkg::CHAR_W-1:0] f_ch;
  logic [wspl_pkg::SCORE_W-1:0] f_w;
  assign f_req = s_tuser;
  assign f_len = s_tdata[4:0];
  assign f_seq = s_tdata[52:5];
  assign f_ch  = s_tdata[73:53];
  assign f_w   = s_tdata[105:74];

  // record memories
  logic [wspl_pkg::CHAR_W-1:0]  mem_ch  [TABLE_DEPTH];
  logic [wspl_pkg::SCORE_W-1:0] mem_sc  [TABLE_DEPTH];
  logic [wspl_pkg::LEN_W-1:0]   mem_len [TABLE_DEPTH];
  logic [SW-1:0]                mem_seq [TABLE_DEPTH];

  logic [CW-1:0] rec_count;
  // copy of the newest record for the order check
  logic [SW-1:0]                last_seq;
  logic [wspl_pkg::LEN_W-1:0]   last_len;
  logic [wspl_pkg::CHAR_W-1:0]  last_ch;

  // held request
  logic [SW-1:0]              q_seq;
  logic [wspl_pkg::LEN_W-1:0] q_len;
  logic [wspl_pkg::CHAR_W-1:0] q_ch;
  logic [wspl_pkg::SCORE_W-1:0] q_w;
  logic [2:0]                 one_status;

  logic [CW-1:0] rd_idx;
  logic          rd_vld;
  logic [wspl_pkg::CHAR_W-1:0]  rd_ch;
  logic [wspl_pkg::SCORE_W-1:0] rd_sc;
  logic [wspl_pkg::LEN_W-1:0]   rd_len;
  logic [SW-1:0]                rd_seq;
  logic [KW-1:0]  flush_cnt;
  logic [KW-1:0]  out_cnt;
  logic           trunc;

  // input checks
  logic bad_load_code, bad_query_code;
  logic [SW-1:0] in_seq_m;
  always_comb begin
    bad_load_code  = 1'b0;
    bad_query_code = 1'b0;
    in_seq_m = '0;
    for (int i = 0; i < MAX_STROKES; i++) begin
      if (i < f_len) begin
        in_seq_m[3*i +: 3] = f_seq[3*i +: 3];
        if (f_seq[3*i +: 3] < 3'd1 || f_seq[3*i +: 3] > 3'd5) bad_load_code = 1'b1;
        if (f_seq[3*i +: 3] != wspl_pkg::WILDCARD &&
            (f_seq[3*i +: 3] < 3'd1 || f_seq[3*i +: 3] > 3'd5)) bad_query_code = 1'b1;
      end
    end
  end

  logic bad_char;
  assign bad_char = (f_ch == '0) || (f_ch > 21'h10FFFF) ||
                    (f_ch >= 21'h00D800 && f_ch <= 21'h00DFFF);

  // lexicographic compare of the new record against the newest stored one
  logic new_after;
  always_comb begin
    logic decided;
    decided   = 1'b0;
    new_after = 1'b0;
    for (int i = 0; i < MAX_STROKES; i++) begin
      if (!decided && i < q_len && i < last_len) begin
        if (q_seq[3*i +: 3] != last_seq[3*i +: 3]) begin
          decided   = 1'b1;
          new_after = q_seq[3*i +: 3] > last_seq[3*i +: 3];
        end
      end
    end
    if (!decided) begin
      if (q_len != last_len) new_after = q_len > last_len;
      else                   new_after = q_ch > last_ch;
    end
  end

  // match of the record read last cycle
  logic rd_match, rd_exact;
  always_comb begin
    rd_match = rd_len >= q_len;
    for (int i = 0; i < MAX_STROKES; i++) begin
      if (i < q_len && q_seq[3*i +: 3] != wspl_pkg::WILDCARD &&
          q_seq[3*i +: 3] != rd_seq[3*i +: 3]) rd_match = 1'b0;
    end
    rd_exact = rd_len == q_len;
  end

  // cell row
  wspl_pkg::cand_t ins_cand;
  wspl_pkg::cand_t cell_in   [NC];
  wspl_pkg::cand_t cell_held [NC];
  wspl_pkg::cand_t cell_pass [NC];
  logic row_clr, row_ins, row_shift;

  always_comb begin
    ins_cand.vld   = rd_vld && rd_match;
    ins_cand.ch    = rd_ch;
    ins_cand.score = rd_sc;
    ins_cand.exact = rd_exact;
  end

  for (genvar g = 0; g < NC; g++) begin : g_cell
    wspl_pkg::cand_t sh_in;
    if (g == NC - 1) begin : g_end
      assign sh_in = '0;
    end else begin : g_mid
      assign sh_in = cell_held[g+1];
    end
    if (g == 0) begin : g_first
      assign cell_in[g] = ins_cand;
    end else begin : g_rest
      assign cell_in[g] = cell_pass[g-1];
    end
    wspl_cell u_cell (
      .clk      (clk),
      .clr      (row_clr),
      .ins_en   (row_ins),
      .in_cand  (cell_in[g]),
      .shift_en (row_shift),
      .shift_in (sh_in),
      .held     (cell_held[g]),
      .pass_out (cell_pass[g])
    );
  end

  assign row_clr   = (state == S_IDLE);
  assign row_ins   = (state == S_SCAN) || (state == S_FLUSH);
  assign row_shift = (state == S_OUT) && m_tready && cell_held[0].vld && out_cnt != '0;

  assign s_tready = (state == S_IDLE);
  logic acc;
  assign acc = s_tvalid && s_tready;

  // output
  always_comb begin
    m_tvalid = 1'b0;
    m_tdata  = '0;
    m_tlast  = 1'b1;
    if (state == S_ONE) begin
      m_tvalid = 1'b1;
      m_tdata[2:0] = one_status;
    end else if (state == S_OUT) begin
      m_tvalid = 1'b1;
      if (cell_held[0].vld && out_cnt != '0) begin
        m_tdata[2:0]   = trunc ? wspl_pkg::ST_TRUNC : wspl_pkg::ST_OK;
        m_tdata[3]     = 1'b1;
        m_tdata[24:4]  = cell_held[0].ch;
        m_tdata[56:25] = cell_held[0].score;
        m_tdata[57]    = cell_held[0].exact;
        m_tlast        = (out_cnt == KW'(1)) || !cell_held[1 % NC].vld || NC == 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      rec_count <= '0;
      rd_vld    <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          rd_vld <= 1'b0;
          trunc  <= 1'b0;
          if (acc) begin
            q_seq <= in_seq_m;
            q_len <= f_len;
            q_ch  <= f_ch;
            q_w   <= f_w;
            one_status <= wspl_pkg::ST_OK;
            state <= S_ONE;
            priority case (f_req)
              wspl_pkg::REQ_CLEAR: rec_count <= '0;
              wspl_pkg::REQ_LOAD: begin
                if (f_len > MAX_STROKES) one_status <= wspl_pkg::ST_TOO_LONG;
                else if (f_len == '0) one_status <= wspl_pkg::ST_BAD_REC;
                else if (bad_load_code) one_status <= wspl_pkg::ST_BAD_STROKE;
                else if (bad_char) one_status <= wspl_pkg::ST_BAD_REC;
                else if (rec_count >= CW'(TABLE_DEPTH)) one_status <= wspl_pkg::ST_FULL;
                else state <= S_LOAD;
              end
              wspl_pkg::REQ_QUERY: begin
                if (f_len > MAX_STROKES) one_status <= wspl_pkg::ST_TOO_LONG;
                else if (bad_query_code) one_status <= wspl_pkg::ST_BAD_STROKE;
                else if (f_len != '0) begin
                  rd_idx <= '0;
                  state  <= S_SCAN;
                end
              end
              default: ;
            endcase
          end
        end
        S_LOAD: begin
          state <= S_ONE;
          if (rec_count != '0 && !new_after) begin
            one_status <= wspl_pkg::ST_MISORDER;
          end else begin
            mem_ch[rec_count[AW-1:0]]  <= q_ch;
            mem_sc[rec_count[AW-1:0]]  <= q_w;
            mem_len[rec_count[AW-1:0]] <= q_len;
            mem_seq[rec_count[AW-1:0]] <= q_seq;
            last_seq  <= q_seq;
            last_len  <= q_len;
            last_ch   <= q_ch;
            rec_count <= rec_count + CW'(1);
          end
        end
        S_SCAN: begin
          if (rd_idx < rec_count) begin
            rd_ch  <= mem_ch[rd_idx[AW-1:0]];
            rd_sc  <= mem_sc[rd_idx[AW-1:0]];
            rd_len <= mem_len[rd_idx[AW-1:0]];
            rd_seq <= mem_seq[rd_idx[AW-1:0]];
            rd_vld <= 1'b1;
            rd_idx <= rd_idx + CW'(1);
          end else begin
            rd_vld    <= 1'b0;
            flush_cnt <= '0;
            state     <= S_FLUSH;
          end
          // a candidate pushed out of the last cell is lost
          if (cell_pass[NC-1].vld) trunc <= 1'b1;
        end
        S_FLUSH: begin
          rd_vld <= 1'b0;
          if (cell_pass[NC-1].vld) trunc <= 1'b1;
          // let carries ripple through every cell
          if (flush_cnt == KW'(NC)) begin
            out_cnt <= KW'(NC);
            state   <= S_OUT;
          end else begin
            flush_cnt <= flush_cnt + KW'(1);
          end
        end
        S_OUT: begin
          if (m_tready) begin
            if (!cell_held[0].vld || out_cnt == '0 || m_tlast) state <= S_IDLE;
            else out_cnt <= out_cnt - KW'(1);
          end
        end
        S_ONE: begin
          if (m_tready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sim/testbench.sv =====
// testbench for wildcard_stroke_prefix_lookup: loads, clears and wildcard queries
// carries its own model of the record table and checks every result field by field
// depends on wspl_pkg and the block's rtl
`timescale 1ns / 1ps

module testbench;

  localparam int NSTROKE = 16;
  localparam int NDEPTH  = 1024;
  localparam int NCAND   = 64;
  localparam int WATCHDOG_LIMIT = 40000;
  localparam int STALL_CYCLES = 600;
  localparam int SQW = wspl_pkg::SEQ_W;
  localparam int CHW = wspl_pkg::CHAR_W;
  localparam int SCW = wspl_pkg::SCORE_W;

  typedef struct packed {
    wspl_pkg::req_t kind;
    logic [4:0]     len;
    logic [SQW-1:0] codes;
    logic [CHW-1:0] ch;
    logic [SCW-1:0] wt;
  } lookup_req_t;

  typedef struct packed {
    wspl_pkg::status_t st;
    logic              has;
    logic [CHW-1:0]    ch;
    logic [SCW-1:0]    score;
    logic              exact;
    logic              last;
  } lookup_rsp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [111:0] s_tdata = '0;
  logic [1:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [63:0] m_tdata;
  logic m_tlast;

  wildcard_stroke_prefix_lookup u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // table mirror
  logic [CHW-1:0] tbl_ch [NDEPTH];
  logic [SCW-1:0] tbl_score [NDEPTH];
  logic [4:0]     tbl_len [NDEPTH];
  logic [SQW-1:0] tbl_seq [NDEPTH];
  int tbl_count = 0;

  lookup_req_t pending_reqs[$];
  lookup_rsp_t expected_rsps[$];
  int errors = 0;
  int n_sent = 0, n_rsp = 0, n_trunc = 0, n_hits = 0;
  bit stall_req = 0;
  bit stall_seen = 0;
  int hold_cnt = 0;
  int idle_cycles = 0;

  function automatic void add_req(lookup_req_t q);
    pending_reqs.insert(pending_reqs.size(), q);
  endfunction

  function automatic void add_rsp(lookup_rsp_t r);
    expected_rsps.insert(expected_rsps.size(), r);
  endfunction

  function automatic logic [2:0] code_of(logic [SQW-1:0] s, int p);
    return s[3*p +: 3];
  endfunction

  function automatic void push_single(wspl_pkg::status_t st);
    lookup_rsp_t r;
    r = '0;
    r.st = st;
    r.last = 1'b1;
    add_rsp(r);
  endfunction

  // negative when (sa,la,ca) sorts before (sb,lb,cb)
  function automatic int seq_order(logic [SQW-1:0] sa, int la, int ca,
                                   logic [SQW-1:0] sb, int lb, int cb);
    int n;
    n = la < lb ? la : lb;
    for (int i = 0; i < n; i++)
      if (code_of(sa, i) != code_of(sb, i))
        return code_of(sa, i) < code_of(sb, i) ? -1 : 1;
    if (la != lb) return la < lb ? -1 : 1;
    if (ca != cb) return ca < cb ? -1 : 1;
    return 0;
  endfunction

  function automatic void apply_load(lookup_req_t q);
    logic [SQW-1:0] s;
    int l;
    l = q.len;
    if (l > NSTROKE) begin push_single(wspl_pkg::ST_TOO_LONG); return; end
    if (l == 0) begin push_single(wspl_pkg::ST_BAD_REC); return; end
    for (int i = 0; i < l; i++)
      if (code_of(q.codes, i) < 1 || code_of(q.codes, i) > 5) begin
        push_single(wspl_pkg::ST_BAD_STROKE);
        return;
      end
    if (q.ch == 0 || q.ch > 21'h10FFFF || (q.ch >= 21'hD800 && q.ch <= 21'hDFFF)) begin
      push_single(wspl_pkg::ST_BAD_REC);
      return;
    end
    if (tbl_count >= NDEPTH) begin push_single(wspl_pkg::ST_FULL); return; end
    s = '0;
    for (int i = 0; i < l; i++) s[3*i +: 3] = code_of(q.codes, i);
    if (tbl_count > 0 && seq_order(tbl_seq[tbl_count-1], tbl_len[tbl_count-1],
        tbl_ch[tbl_count-1], s, l, q.ch) >= 0) begin
      push_single(wspl_pkg::ST_MISORDER);
      return;
    end
    tbl_ch[tbl_count] = q.ch;
    tbl_score[tbl_count] = q.wt;
    tbl_len[tbl_count] = q.len;
    tbl_seq[tbl_count] = s;
    tbl_count++;
    push_single(wspl_pkg::ST_OK);
  endfunction

  function automatic void apply_query(lookup_req_t q);
    lookup_rsp_t cands[$];
    lookup_rsp_t c;
    int l, j;
    bit ok, trunc;
    l = q.len;
    trunc = 0;
    if (l > NSTROKE) begin push_single(wspl_pkg::ST_TOO_LONG); return; end
    for (int i = 0; i < l; i++)
      if (code_of(q.codes, i) != wspl_pkg::WILDCARD &&
          (code_of(q.codes, i) < 1 || code_of(q.codes, i) > 5)) begin
        push_single(wspl_pkg::ST_BAD_STROKE);
        return;
      end
    if (l == 0) begin push_single(wspl_pkg::ST_OK); return; end
    for (int r = 0; r < tbl_count; r++) begin
      ok = tbl_len[r] >= l;
      for (int i = 0; ok && i < l; i++)
        if (code_of(q.codes, i) != wspl_pkg::WILDCARD &&
            code_of(q.codes, i) != code_of(tbl_seq[r], i))
          ok = 0;
      if (!ok) continue;
      j = 0;
      while (j < cands.size() && cands[j].ch < tbl_ch[r]) j++;
      if (j < cands.size() && cands[j].ch == tbl_ch[r]) begin
        if (tbl_score[r] > cands[j].score) cands[j].score = tbl_score[r];
        cands[j].exact |= (tbl_len[r] == l);
        continue;
      end
      if (cands.size() >= NCAND) begin
        trunc = 1;
        if (j >= cands.size()) continue;
        void'(cands.pop_back());
      end
      c = '0;
      c.has = 1'b1;
      c.ch = tbl_ch[r];
      c.score = tbl_score[r];
      c.exact = (tbl_len[r] == l);
      cands.insert(j, c);
    end
    if (cands.size() == 0) begin push_single(wspl_pkg::ST_OK); return; end
    if (trunc) n_trunc++;
    n_hits++;
    foreach (cands[k]) begin
      cands[k].st = trunc ? wspl_pkg::ST_TRUNC : wspl_pkg::ST_OK;
      cands[k].last = (k == cands.size() - 1);
      add_rsp(cands[k]);
    end
  endfunction

  function automatic void predict(lookup_req_t q);
    case (q.kind)
      wspl_pkg::REQ_CLEAR: begin
        tbl_count = 0;
        push_single(wspl_pkg::ST_OK);
      end
      wspl_pkg::REQ_LOAD: apply_load(q);
      wspl_pkg::REQ_QUERY: apply_query(q);
      default: push_single(wspl_pkg::ST_OK);
    endcase
  endfunction

  function automatic int short_gap();
    return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
  endfunction

  // driver
  int send_gap = 0;
  lookup_req_t cur_req;
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        predict(cur_req);
        n_sent++;
      end
      if (!s_tvalid || s_tready) begin
        if (send_gap > 0 || pending_reqs.size() == 0) begin
          if (send_gap > 0) send_gap <= send_gap - 1;
          s_tvalid <= 1'b0;
        end else begin
          cur_req = pending_reqs.pop_front();
          s_tvalid <= 1'b1;
          s_tuser <= cur_req.kind;
          s_tdata <= {6'b0, cur_req.wt, cur_req.ch, cur_req.codes, cur_req.len};
          send_gap <= ($urandom_range(0, 2) == 0) ? short_gap() : 0;
        end
      end
    end
  end

  // monitor and receiver stall
  int recv_gap = 0;
  lookup_rsp_t got, want;
  always @(posedge clk) begin
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got = {wspl_pkg::status_t'(m_tdata[2:0]), m_tdata[3], m_tdata[24:4],
               m_tdata[56:25], m_tdata[57], m_tlast};
        n_rsp++;
        if (expected_rsps.size() == 0) begin
          $display("%0t: result expected none actual %p", $time, got);
          errors++;
        end else begin
          want = expected_rsps.pop_front();
          if (got.st != want.st)
            $display("%0t: status expected %0d actual %0d", $time, want.st, got.st);
          if (got.has != want.has)
            $display("%0t: has_candidate expected %0d actual %0d", $time, want.has, got.has);
          if (got.ch != want.ch)
            $display("%0t: cand_char expected %h actual %h", $time, want.ch, got.ch);
          if (got.score != want.score)
            $display("%0t: cand_score expected %h actual %h", $time, want.score, got.score);
          if (got.exact != want.exact)
            $display("%0t: exact_hit expected %0d actual %0d", $time, want.exact, got.exact);
          if (got.last != want.last)
            $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
          if (got != want) errors++;
        end
      end
      // one long stall on request, counted here
      if (stall_req && !stall_seen) begin
        stall_seen <= 1'b1;
        hold_cnt <= STALL_CYCLES;
        m_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 1'b0;
      end else if (recv_gap > 0) begin
        recv_gap <= recv_gap - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if ($urandom_range(0, 3) == 0) recv_gap <= short_gap();
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no traffic for %0d cycles", WATCHDOG_LIMIT);
      $display("tb: failure");
      $finish;
    end
  end

  // stimulus builders
  function automatic lookup_req_t mk(wspl_pkg::req_t k, int l, logic [SQW-1:0] s,
                                     logic [CHW-1:0] c, logic [SCW-1:0] w);
    lookup_req_t q;
    q.kind = k;
    q.len = 5'(l);
    q.codes = s;
    q.ch = c;
    q.wt = w;
    return q;
  endfunction

  function automatic logic [SQW-1:0] rnd_seq();
    logic [63:0] r;
    r = {$urandom, $urandom};
    return r[SQW-1:0];
  endfunction

  function automatic logic [SQW-1:0] rand_strokes(int l, int wild_pct);
    logic [SQW-1:0] s;
    s = rnd_seq();
    for (int i = 0; i < l; i++)
      s[3*i +: 3] = ($urandom_range(0, 99) < wild_pct) ? wspl_pkg::WILDCARD :
                    3'($urandom_range(1, 5));
    return s;
  endfunction

  // ordered load batch on a small alphabet so queries hit many records
  task automatic add_ordered_batch(int n, int maxlen);
    logic [SQW-1:0] s;
    int l, nc;
    s = '0;
    l = 1;
    s[2:0] = 3'd1;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 2) != 0 && l < maxlen) begin
        l++;
        s[3*(l-1) +: 3] = 3'($urandom_range(1, 5));
      end else begin
        while (l > 1 && s[3*(l-1) +: 3] == 3'd5) begin s[3*(l-1) +: 3] = 3'd0; l--; end
        if (s[3*(l-1) +: 3] == 3'd5) break;
        s[3*(l-1) +: 3] = s[3*(l-1) +: 3] + 3'd1;
      end
      nc = $urandom_range(1, 2);
      for (int c = 1; c <= nc; c++)
        add_req(mk(wspl_pkg::REQ_LOAD, l, s | (rnd_seq() << (3*l)),
                   CHW'(c * 37 + $urandom_range(0, 36)), $urandom));
    end
  endtask

  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_reqs.size() != 0 || s_tvalid || expected_rsps.size() != 0);
  endtask

  initial begin
    lookup_req_t q;
    int l;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: every check but the full table, and extremes
    add_req(mk(wspl_pkg::REQ_QUERY, 1, 48'o7, '0, '0));
    add_req(mk(wspl_pkg::REQ_LOAD, 1, 48'o1, 21'h10FFFF, 32'hFFFFFFFF));
    add_req(mk(wspl_pkg::REQ_LOAD, 2, 48'o11, 21'h000001, 32'h0));
    add_req(mk(wspl_pkg::REQ_LOAD, 2, 48'o51, 21'h00D7FF, 32'h5));
    add_req(mk(wspl_pkg::REQ_LOAD, 16, 48'o5555555555555555, 21'h00E000, 32'h9));
    add_req(mk(wspl_pkg::REQ_LOAD, 16, 48'o5555555555555555, 21'h00E000, 32'h9));
    add_req(mk(wspl_pkg::REQ_LOAD, 1, 48'o1, 21'h5, 32'h1));
    add_req(mk(wspl_pkg::REQ_LOAD, 17, 48'o1, 21'h5, 32'h1));
    add_req(mk(wspl_pkg::REQ_LOAD, 31, '1, '1, '1));
    add_req(mk(wspl_pkg::REQ_LOAD, 0, 48'o1, 21'h5, 32'h1));
    add_req(mk(wspl_pkg::REQ_LOAD, 2, 48'o61, 21'h5, 32'h1));
    add_req(mk(wspl_pkg::REQ_LOAD, 2, 48'o71, 21'h5, 32'h1));
    add_req(mk(wspl_pkg::REQ_LOAD, 1, 48'o0, 21'h5, 32'h1));
    add_req(mk(wspl_pkg::REQ_LOAD, 3, 48'o111, 21'h0, 32'h1));
    add_req(mk(wspl_pkg::REQ_LOAD, 3, 48'o111, 21'h00D800, 32'h1));
    add_req(mk(wspl_pkg::REQ_LOAD, 3, 48'o111, 21'h00DFFF, 32'h1));
    add_req(mk(wspl_pkg::REQ_LOAD, 3, 48'o111, 21'h110000, 32'h1));
    add_req(mk(wspl_pkg::REQ_QUERY, 1, {{(SQW-3){1'b1}}, 3'o7}, '0, '0));
    add_req(mk(wspl_pkg::REQ_QUERY, 16, 48'o7777777777777777, '0, '0));
    add_req(mk(wspl_pkg::REQ_QUERY, 0, '1, '1, '1));
    add_req(mk(wspl_pkg::REQ_QUERY, 17, 48'o7, '0, '0));
    add_req(mk(wspl_pkg::REQ_QUERY, 2, 48'o61, '0, '0));
    add_req(mk(wspl_pkg::REQ_QUERY, 2, 48'o03, '0, '0));
    add_req(mk(wspl_pkg::REQ_NONE, 3, '1, '1, '1));
    add_req(mk(wspl_pkg::REQ_CLEAR, 31, '1, '1, '1));
    wait_drained();

    // more distinct characters than the row holds, then broad queries
    add_req(mk(wspl_pkg::REQ_CLEAR, 0, '0, '0, '0));
    for (int i = 0; i < 100; i++)
      add_req(mk(wspl_pkg::REQ_LOAD, 1 + (i >= 80), (i >= 80) ? 48'o12 : 48'o1,
                 CHW'(1 + (i % 80)), $urandom));
    add_req(mk(wspl_pkg::REQ_QUERY, 1, 48'o1, '0, '0));
    add_req(mk(wspl_pkg::REQ_QUERY, 1, 48'o7, '0, '0));
    wait_drained();

    // long receiver stall while the sender keeps offering
    add_req(mk(wspl_pkg::REQ_CLEAR, 0, '0, '0, '0));
    for (int i = 0; i < 40; i++)
      add_req(mk(wspl_pkg::REQ_LOAD, 1, SQW'($urandom_range(1, 5)), CHW'(32'h40 + i),
                 $urandom));
    stall_req = 1;
    wait_drained();

    // random part: ordered batches and queries, with noise
    while (n_sent < 470) begin
      add_req(mk(wspl_pkg::REQ_CLEAR, $urandom, rnd_seq(), CHW'($urandom), $urandom));
      add_ordered_batch($urandom_range(10, 60), $urandom_range(2, 6));
      for (int k = 0; k < $urandom_range(6, 14); k++) begin
        case ($urandom_range(0, 9))
          0: q = mk(wspl_pkg::req_t'(2'($urandom_range(0, 3))), $urandom, rnd_seq(),
                    CHW'($urandom), $urandom);
          1: begin
            l = $urandom_range(1, 16);
            q = mk(wspl_pkg::REQ_LOAD, l, rand_strokes(l, 0),
                   CHW'($urandom_range(1, 32'h10FFFF)), $urandom);
          end
          default: begin
            l = $urandom_range(1, 5);
            q = mk(wspl_pkg::REQ_QUERY, l, rand_strokes(l, $urandom_range(0, 80)),
                   CHW'($urandom), $urandom);
          end
        endcase
        add_req(q);
      end
      wait_drained();
    end

    wait_drained();
    repeat (NDEPTH + NCAND + 20) @(posedge clk);
    $display("summary: %0d requests, %0d results, %0d queries with candidates, %0d truncated",
             n_sent, n_rsp, n_hits, n_trunc);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
